### rtl/core/qe_pkg.sv
// Shared types, constants and helper functions of the quaternion to
// roll/pitch/yaw converter. Used by every file in rtl/core.
package qe_pkg;

  localparam int QUAT_W        = 16;
  localparam int QFRAC         = QUAT_W - 2;
  localparam int ANG_W         = 16;
  localparam int AFRAC         = ANG_W - 3;
  localparam int ASHIFT        = 30 - AFRAC;
  localparam int CORDIC_STAGES = 16;
  localparam int ISQRT_STEPS   = QFRAC + 1;
  localparam int NORM_STEPS    = 7;
  localparam int NORM_EXP      = 40;
  localparam int LANE_W        = 48;
  localparam int Z_W           = 34;
  localparam int SUM_W         = 20;
  localparam int PROD_W        = 18;
  localparam int SQN_W         = 2 * QFRAC + 1;
  localparam int SQR_W         = 2 * QFRAC + 2;

  localparam logic signed [Z_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ANG_W-1:0] PI_LIM    = 16'sd25736;
  localparam logic signed [ANG_W-1:0] HALF_LIM  = 16'sd12868;

  // Truncated Q.30 arctangent table, atan(2^-i)
  localparam logic signed [Z_W-1:0] ATAN_TAB [30] = '{
    34'sh3243F6A8, 34'sh1DAC6705, 34'sh0FADBAFC, 34'sh07F56EA6, 34'sh03FEAB76,
    34'sh01FFD55B, 34'sh00FFFAAA, 34'sh007FFF55, 34'sh003FFFEA, 34'sh001FFFFD,
    34'sh000FFFFF, 34'sh0007FFFF, 34'sh0003FFFF, 34'sh0001FFFF, 34'sh0000FFFF,
    34'sh00007FFF, 34'sh00003FFF, 34'sh00001FFF, 34'sh00000FFF, 34'sh000007FF,
    34'sh000003FF, 34'sh000001FF, 34'sh000000FF, 34'sh0000007F, 34'sh0000003F,
    34'sh0000001F, 34'sh0000000F, 34'sh00000007, 34'sh00000003, 34'sh00000001
  };

  // One arctangent operand pair with its angle accumulator
  typedef struct packed {
    logic signed [LANE_W-1:0] x;
    logic signed [LANE_W-1:0] y;
    logic signed [Z_W-1:0]    z;
    logic                     zero;
    logic                     ok;
    logic [6:0]               m;
  } lane_t;

  // Everything one item carries down the cell chain
  typedef struct packed {
    lane_t            roll;
    lane_t            pitch;
    lane_t            yaw;
    logic             clamped;
    logic             clamp_pos;  // clamped with a positive pitch sine
    logic [SQN_W-1:0] sq_n;
    logic [SQR_W-1:0] sq_res;
  } item_t;

  // True while (x, y) scaled by 2^t stays inside the normalization window
  function automatic logic norm_fits(input logic signed [LANE_W-1:0] x,
                                     input logic signed [LANE_W-1:0] y,
                                     input logic [6:0] t);
    logic signed [LANE_W-1:0] lim;
    lim = '0;
    if (t > 7'(NORM_EXP)) begin
      return 1'b0;
    end
    lim = LANE_W'(1) <<< (7'(NORM_EXP) - t);
    return (x < lim) && (y < lim) && (y > -lim);
  endfunction

  // Shift amount of each search step; the last step applies the shift
  function automatic logic [6:0] norm_step(input logic [2:0] idx);
    logic [6:0] s;
    s = '0;
    if (idx < 3'd6) begin
      s = 7'd32 >> idx;
    end
    return s;
  endfunction

  // Zero test, left-half-plane fold and first window test
  function automatic lane_t lane_start(input lane_t l);
    lane_t r;
    r      = l;
    r.z    = '0;
    r.m    = '0;
    r.zero = (l.x == '0) && (l.y == '0);
    if (l.x < 0) begin
      if (l.y >= 0) begin
        r.x = l.y;
        r.y = -l.x;
        r.z = HALF_PI_Q30;
      end else begin
        r.x = -l.y;
        r.y = l.x;
        r.z = -HALF_PI_Q30;
      end
    end
    r.ok = norm_fits(r.x, r.y, 7'd0);
    return r;
  endfunction

endpackage

### rtl/core/qe_isqrt_cell.sv
// One bit-pair step of the integer square root of 1 - s*s for the pitch lane.
// Depends on qe_pkg.
module qe_isqrt_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [3:0]    idx_i,
  input  logic          valid_i,
  input  qe_pkg::item_t item_i,
  output logic          valid_o,
  output qe_pkg::item_t item_o
);
  import qe_pkg::*;

  logic          valid_q;
  item_t         item_q, item_d;
  logic [SQR_W-1:0] bit_w, trial;

  // Restoring square-root step with bit = 4^(QFRAC - idx)
  always_comb begin
    item_d = item_i;
    bit_w  = SQR_W'(1) << (5'(2 * QFRAC) - {idx_i, 1'b0});
    trial  = item_i.sq_res + bit_w;
    if (SQR_W'(item_i.sq_n) >= trial) begin
      item_d.sq_n   = item_i.sq_n - trial[SQN_W-1:0];
      item_d.sq_res = (item_i.sq_res >> 1) + bit_w;
    end else begin
      item_d.sq_res = item_i.sq_res >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### rtl/core/qe_prerot_cell.sv
// Folds each arctangent operand pair into the right half plane and loads
// the pitch cosine from the square root. Depends on qe_pkg.
module qe_prerot_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  qe_pkg::item_t item_i,
  output logic          valid_o,
  output qe_pkg::item_t item_o
);
  import qe_pkg::*;

  logic  valid_q;
  item_t item_q, item_d;
  lane_t pitch_in;

  always_comb begin
    pitch_in   = item_i.pitch;
    pitch_in.x = LANE_W'(item_i.sq_res);
    item_d       = item_i;
    item_d.roll  = lane_start(item_i.roll);
    item_d.pitch = lane_start(pitch_in);
    item_d.yaw   = lane_start(item_i.yaw);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### rtl/core/qe_norm_cell.sv
// One step of the binary search for the normalizing shift; the last step
// applies the shift. Depends on qe_pkg.
module qe_norm_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [2:0]    idx_i,
  input  logic          valid_i,
  input  qe_pkg::item_t item_i,
  output logic          valid_o,
  output qe_pkg::item_t item_o
);
  import qe_pkg::*;

  logic  valid_q;
  item_t item_q, item_d;

  function automatic lane_t lane_norm(input lane_t l, input logic [6:0] s);
    lane_t      r;
    logic [6:0] k;
    r = l;
    k = '0;
    if (s == '0) begin
      // shift count is one past the last scale that still fit
      k   = l.ok ? l.m + 7'd1 : 7'd0;
      r.x = l.x <<< k;
      r.y = l.y <<< k;
    end else if (l.ok && norm_fits(l.x, l.y, l.m + s)) begin
      r.m = l.m + s;
    end
    return r;
  endfunction

  always_comb begin
    item_d       = item_i;
    item_d.roll  = lane_norm(item_i.roll, norm_step(idx_i));
    item_d.pitch = lane_norm(item_i.pitch, norm_step(idx_i));
    item_d.yaw   = lane_norm(item_i.yaw, norm_step(idx_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### rtl/core/qe_cordic_cell.sv
// One vectoring CORDIC micro-rotation on all three lanes.
// Depends on qe_pkg.
module qe_cordic_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [3:0]    idx_i,
  input  logic          valid_i,
  input  qe_pkg::item_t item_i,
  output logic          valid_o,
  output qe_pkg::item_t item_o
);
  import qe_pkg::*;

  logic  valid_q;
  item_t item_q, item_d;

  function automatic lane_t lane_rot(input lane_t l, input logic [3:0] i);
    lane_t r;
    logic signed [LANE_W-1:0] xs, ys;
    r  = l;
    xs = l.y >>> i;
    ys = l.x >>> i;
    if (!l.zero) begin
      if (l.y >= 0) begin
        r.x = l.x + xs;
        r.y = l.y - ys;
        r.z = l.z + ATAN_TAB[i];
      end else begin
        r.x = l.x - xs;
        r.y = l.y + ys;
        r.z = l.z - ATAN_TAB[i];
      end
    end
    return r;
  endfunction

  always_comb begin
    item_d       = item_i;
    item_d.roll  = lane_rot(item_i.roll, idx_i);
    item_d.pitch = lane_rot(item_i.pitch, idx_i);
    item_d.yaw   = lane_rot(item_i.yaw, idx_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### rtl/core/quaternion_to_euler_angles.sv
// Quaternion (Q2.14) to roll/pitch/yaw (Q3.13) converter, top level.
// Throughput one item per cycle while the output does not stall, set by the fully
// pipelined cell chain (15 square-root cells, 1 fold cell, 7 normalize cells,
// 16 CORDIC cells) under one common enable.
// Reset (rst_ni low, asynchronous) empties the pipeline; no clearing pass.
// Depends on qe_pkg and the qe_*_cell modules.
module quaternion_to_euler_angles (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // roll_angle, pitch_angle, yaw_angle, 0
  output logic        m_axis_tuser    // pitch_clamped
);
  import qe_pkg::*;

  localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1) <<< QFRAC;

  logic en;

  // Input register
  logic v0_q;
  logic signed [QUAT_W-1:0] w_q, x_q, y_q, z_q;

  // Component products, floored to Q.14
  logic v1_q;
  logic signed [PROD_W-1:0] wx_q, yz_q, xx_q, yy_q, wy_q, zx_q, wz_q, xy_q, zz_q;

  // Sine and cosine terms
  logic v2_q;
  logic signed [SUM_W-1:0] sr_q, cr_q, sp_q, sy_q, cy_q;

  // Item build
  logic  v3_q;
  item_t it3_q, it3_d;
  logic  clamp3;
  logic signed [QUAT_W-1:0] sp16;
  logic signed [2*QUAT_W-1:0] sp_sq;

  // Output register
  logic        out_v_q;
  logic signed [ANG_W-1:0] roll_q, pitch_q, yaw_q;
  logic        clamp_q;
  logic signed [ANG_W-1:0] roll_d, pitch_d, yaw_d;

  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  function automatic logic signed [PROD_W-1:0] qmul(input logic signed [QUAT_W-1:0] a,
                                                    input logic signed [QUAT_W-1:0] b);
    logic signed [2*QUAT_W-1:0] p;
    p = a * b;
    return p[QFRAC +: PROD_W];
  endfunction

  function automatic logic signed [ANG_W-1:0] round_sat(input logic signed [Z_W-1:0] z,
                                                        input logic signed [ANG_W-1:0] lim);
    logic signed [Z_W-1:0] r;
    r = (z + (Z_W'(1) <<< (ASHIFT - 1))) >>> ASHIFT;
    if (r > Z_W'(lim)) begin
      return lim;
    end
    if (r < -Z_W'(lim)) begin
      return -lim;
    end
    return r[ANG_W-1:0];
  endfunction

  // Front control: valid bits of the first four stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Front data: input register, products, sums and the built item
  always_ff @(posedge clk_i) begin
    if (en) begin
      w_q  <= s_axis_tdata[15:0];
      x_q  <= s_axis_tdata[31:16];
      y_q  <= s_axis_tdata[47:32];
      z_q  <= s_axis_tdata[63:48];
      wx_q <= qmul(w_q, x_q);
      yz_q <= qmul(y_q, z_q);
      xx_q <= qmul(x_q, x_q);
      yy_q <= qmul(y_q, y_q);
      wy_q <= qmul(w_q, y_q);
      zx_q <= qmul(z_q, x_q);
      wz_q <= qmul(w_q, z_q);
      xy_q <= qmul(x_q, y_q);
      zz_q <= qmul(z_q, z_q);
      sr_q <= (SUM_W'(wx_q) + SUM_W'(yz_q)) <<< 1;
      cr_q <= ONE - ((SUM_W'(xx_q) + SUM_W'(yy_q)) <<< 1);
      sp_q <= (SUM_W'(wy_q) - SUM_W'(zx_q)) <<< 1;
      sy_q <= (SUM_W'(wz_q) + SUM_W'(xy_q)) <<< 1;
      cy_q <= ONE - ((SUM_W'(yy_q) + SUM_W'(zz_q)) <<< 1);
      it3_q <= it3_d;
    end
  end

  // Build the item: clamp test and square-root operand 1 - s*s
  always_comb begin
    clamp3 = (sp_q >= ONE) || (sp_q <= -ONE);
    sp16   = clamp3 ? '0 : sp_q[QUAT_W-1:0];
    sp_sq  = sp16 * sp16;
    it3_d  = '0;
    it3_d.roll.x  = LANE_W'(cr_q);
    it3_d.roll.y  = LANE_W'(sr_q);
    it3_d.yaw.x   = LANE_W'(cy_q);
    it3_d.yaw.y   = LANE_W'(sy_q);
    it3_d.pitch.y = LANE_W'(sp_q);
    it3_d.clamped   = clamp3;
    it3_d.clamp_pos = clamp3 && (sp_q > 0);
    it3_d.sq_n    = (SQN_W'(1) << (2 * QFRAC)) - sp_sq[SQN_W-1:0];
    it3_d.sq_res  = '0;
  end

  // Square-root cells
  logic  isq_v  [ISQRT_STEPS+1];
  item_t isq_it [ISQRT_STEPS+1];
  assign isq_v[0]  = v3_q;
  assign isq_it[0] = it3_q;

  for (genvar g = 0; g < ISQRT_STEPS; g++) begin : g_isqrt
    qe_isqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .idx_i   (4'(g)),
      .valid_i (isq_v[g]),
      .item_i  (isq_it[g]),
      .valid_o (isq_v[g+1]),
      .item_o  (isq_it[g+1])
    );
  end

  // Fold cell
  logic  pre_v;
  item_t pre_it;
  qe_prerot_cell u_prerot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (isq_v[ISQRT_STEPS]),
    .item_i  (isq_it[ISQRT_STEPS]),
    .valid_o (pre_v),
    .item_o  (pre_it)
  );

  // Normalize cells
  logic  nrm_v  [NORM_STEPS+1];
  item_t nrm_it [NORM_STEPS+1];
  assign nrm_v[0]  = pre_v;
  assign nrm_it[0] = pre_it;

  for (genvar g = 0; g < NORM_STEPS; g++) begin : g_norm
    qe_norm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .idx_i   (3'(g)),
      .valid_i (nrm_v[g]),
      .item_i  (nrm_it[g]),
      .valid_o (nrm_v[g+1]),
      .item_o  (nrm_it[g+1])
    );
  end

  // CORDIC cells
  logic  cor_v  [CORDIC_STAGES+1];
  item_t cor_it [CORDIC_STAGES+1];
  assign cor_v[0]  = nrm_v[NORM_STEPS];
  assign cor_it[0] = nrm_it[NORM_STEPS];

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    qe_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .idx_i   (4'(g)),
      .valid_i (cor_v[g]),
      .item_i  (cor_it[g]),
      .valid_o (cor_v[g+1]),
      .item_o  (cor_it[g+1])
    );
  end

  // Rounding, saturation and pitch clamp
  always_comb begin
    roll_d = round_sat(cor_it[CORDIC_STAGES].roll.z, PI_LIM);
    yaw_d  = round_sat(cor_it[CORDIC_STAGES].yaw.z, PI_LIM);
    if (cor_it[CORDIC_STAGES].clamped) begin
      pitch_d = cor_it[CORDIC_STAGES].clamp_pos ? HALF_LIM : -HALF_LIM;
    end else begin
      pitch_d = round_sat(cor_it[CORDIC_STAGES].pitch.z, HALF_LIM);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= cor_v[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q  <= roll_d;
      pitch_q <= pitch_d;
      yaw_q   <= yaw_d;
      clamp_q <= cor_it[CORDIC_STAGES].clamped;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {1'b0, yaw_q, pitch_q[ANG_W-2:0], roll_q};
  assign m_axis_tuser  = clamp_q;

endmodule

### verif/quaternion_to_euler_angles_tb.sv
// Self-checking testbench for quaternion_to_euler_angles: streams quaternions
// in, predicts roll/pitch/yaw in fixed point and checks every result item.
// Depends on qe_pkg and the quaternion_to_euler_angles RTL.
module quaternion_to_euler_angles_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qe_pkg::*;

  localparam int N_RANDOM    = 530;
  localparam int WDOG_LIMIT  = 3000;
  localparam int HOLD_START  = 300;
  localparam int HOLD_LEN    = 250;
  localparam int CALM_START  = 700;
  localparam int CALM_END    = 1000;
  localparam int PAUSE_AT    = 420;
  localparam int DRAIN_WAIT  = 60;
  localparam longint NORM_LIM = longint'(1) <<< NORM_EXP;

  typedef struct packed {
    logic             clamped;
    logic signed [15:0] yaw;
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
  } euler_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;

  logic [63:0] quat_queue[$];
  euler_t      angle_queue[$];
  int          cycle_cnt = 0;
  int          sent_cnt = 0;
  int          idle_cnt = 0;
  int          errors = 0;
  bit          paused_done = 1'b0;

  quaternion_to_euler_angles u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Floored product of two Q2.14 components
  function automatic longint qprod(longint a, longint b);
    return (a * b) >>> QFRAC;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Vectoring CORDIC arctangent, Q.30 radians
  function automatic longint atan2_q30(longint y, longint x);
    longint z, t, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = y; y = -x; x = t; z = HALF_PI_Q30;
      end else begin
        t = -y; y = x; x = t; z = -HALF_PI_Q30;
      end
    end
    while (x < NORM_LIM && y < NORM_LIM && y > -NORM_LIM) begin
      x = x * 2;
      y = y * 2;
    end
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      xs = y >>> i;
      ys = x >>> i;
      if (y >= 0) begin
        x += xs; y -= ys; z += longint'(ATAN_TAB[i]);
      end else begin
        x -= xs; y += ys; z -= longint'(ATAN_TAB[i]);
      end
    end
    return z;
  endfunction

  function automatic longint round_sat(longint q30, longint lim);
    longint v;
    v = (q30 + (longint'(1) <<< (ASHIFT - 1))) >>> ASHIFT;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v;
  endfunction

  function automatic euler_t predict_angles(logic [63:0] d);
    longint w, x, y, z, one, sr, cr, sp, sy, cy, c, pitch;
    euler_t r;
    w = longint'($signed(d[15:0]));
    x = longint'($signed(d[31:16]));
    y = longint'($signed(d[47:32]));
    z = longint'($signed(d[63:48]));
    one = longint'(1) <<< QFRAC;
    sr = 2 * (qprod(w, x) + qprod(y, z));
    cr = one - 2 * (qprod(x, x) + qprod(y, y));
    sp = 2 * (qprod(w, y) - qprod(z, x));
    sy = 2 * (qprod(w, z) + qprod(x, y));
    cy = one - 2 * (qprod(y, y) + qprod(z, z));
    r.roll = 16'(round_sat(atan2_q30(sr, cr), PI_LIM));
    r.yaw  = 16'(round_sat(atan2_q30(sy, cy), PI_LIM));
    if (sp >= one || sp <= -one) begin
      r.clamped = 1'b1;
      pitch = (sp > 0) ? longint'(HALF_LIM) : -longint'(HALF_LIM);
    end else begin
      r.clamped = 1'b0;
      c = longint'(int_sqrt(longint'(one * one - sp * sp)));
      pitch = round_sat(atan2_q30(sp, c), HALF_LIM);
    end
    r.pitch = 15'(pitch);
    return r;
  endfunction

  function automatic logic [63:0] pack_quat(int w, int x, int y, int z);
    return {16'(z), 16'(y), 16'(x), 16'(w)};
  endfunction

  function automatic int to_q14(real v);
    int q;
    q = $rtoi(v * 16384.0);
    if (q > 16384) q = 16384;
    if (q < -16384) q = -16384;
    return q;
  endfunction

  function automatic real rnd_unit();
    return (real'($urandom_range(0, 65536)) - 32768.0) / 32768.0;
  endfunction

  // Stimulus and end of run
  initial begin
    real a, b, c, e, n;
    int  kind;
    // extremes, identity, both pitch clamps, zero arctangent, bad patterns
    quat_queue.push_back(pack_quat(16384, 0, 0, 0));
    quat_queue.push_back(pack_quat(-16384, 0, 0, 0));
    quat_queue.push_back(pack_quat(0, 16384, 0, 0));
    quat_queue.push_back(pack_quat(0, 0, 16384, 0));
    quat_queue.push_back(pack_quat(0, 0, 0, 16384));
    quat_queue.push_back(pack_quat(0, -16384, 0, 0));
    quat_queue.push_back(pack_quat(0, 0, -16384, 0));
    quat_queue.push_back(pack_quat(0, 0, 0, -16384));
    quat_queue.push_back(pack_quat(11585, 0, 11585, 0));
    quat_queue.push_back(pack_quat(11585, 0, -11585, 0));
    quat_queue.push_back(pack_quat(16384, 0, 16384, 0));
    quat_queue.push_back(pack_quat(16384, 0, -16384, 0));
    quat_queue.push_back(pack_quat(0, 8192, 8192, 0));
    quat_queue.push_back(pack_quat(0, 0, 0, 0));
    quat_queue.push_back(pack_quat(16384, 16384, 16384, 16384));
    quat_queue.push_back(pack_quat(-16384, -16384, -16384, -16384));
    quat_queue.push_back(pack_quat(-32768, -32768, -32768, -32768));
    quat_queue.push_back(pack_quat(32767, 32767, 32767, 32767));
    quat_queue.push_back(pack_quat(-32768, 32767, -32768, 32767));
    quat_queue.push_back(pack_quat(8192, 8192, 8192, 8192));
    quat_queue.push_back(pack_quat(11585, 11585, 0, 0));
    quat_queue.push_back(pack_quat(11585, 0, 0, -11585));
    for (int i = 0; i < N_RANDOM; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        // unit quaternion with random direction
        a = rnd_unit(); b = rnd_unit(); c = rnd_unit(); e = rnd_unit();
        n = $sqrt(a * a + b * b + c * c + e * e);
        if (n < 0.01) begin
          a = 1.0; n = 1.0;
        end
        quat_queue.push_back(pack_quat(to_q14(a / n), to_q14(b / n),
                                       to_q14(c / n), to_q14(e / n)));
      end else if (kind < 70) begin
        // close to gimbal lock, either sign
        a = 0.7071 + rnd_unit() * 0.01;
        c = (($urandom_range(0, 1) != 0) ? 0.7071 : -0.7071) + rnd_unit() * 0.01;
        quat_queue.push_back(pack_quat(to_q14(a), $urandom_range(0, 40) - 20,
                                       to_q14(c), $urandom_range(0, 40) - 20));
      end else if (kind < 85) begin
        quat_queue.push_back(pack_quat($urandom_range(0, 32768) - 16384,
                                       $urandom_range(0, 32768) - 16384,
                                       $urandom_range(0, 32768) - 16384,
                                       $urandom_range(0, 32768) - 16384));
      end else begin
        quat_queue.push_back({$urandom(), $urandom()});
      end
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (quat_queue.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (angle_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (errors == 0 && angle_queue.size() == 0) begin
      $display("quaternion_to_euler_angles: match");
    end else begin
      $display("quaternion_to_euler_angles: mismatch");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Sender: random gaps, a calm stretch, one pause until the pipe drains
  always @(posedge clk_i or negedge rst_ni) begin
    bit gap;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      gap = ($urandom_range(0, 99) < 34) && !(cycle_cnt >= CALM_START && cycle_cnt < CALM_END);
      if (sent_cnt == PAUSE_AT && !paused_done) begin
        gap = 1'b1;
        if (!s_axis_tvalid && angle_queue.size() == 0) paused_done = 1'b1;
      end
      if (quat_queue.size() != 0 && !gap) begin
        s_axis_tdata  <= quat_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        sent_cnt      <= sent_cnt + 1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (cycle_cnt >= HOLD_START && cycle_cnt < HOLD_START + HOLD_LEN) begin
      m_axis_tready <= 1'b0;
    end else if (cycle_cnt >= CALM_START && cycle_cnt < CALM_END) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= 34);
    end
  end

  // Monitor: predict on input accept, compare on output accept
  always @(posedge clk_i) begin
    euler_t exp_a;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      angle_queue.push_back(predict_angles(s_axis_tdata));
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (angle_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected item tdata=%h tuser=%b", $realtime, m_axis_tdata,
                 m_axis_tuser);
      end else begin
        exp_a = angle_queue.pop_front();
        if (m_axis_tdata[15:0] !== exp_a.roll) begin
          errors++;
          $display("%0t: roll expected %0d actual %0d", $realtime, exp_a.roll,
                   $signed(m_axis_tdata[15:0]));
        end
        if (m_axis_tdata[30:16] !== exp_a.pitch) begin
          errors++;
          $display("%0t: pitch expected %0d actual %0d", $realtime, exp_a.pitch,
                   $signed(m_axis_tdata[30:16]));
        end
        if (m_axis_tdata[46:31] !== exp_a.yaw) begin
          errors++;
          $display("%0t: yaw expected %0d actual %0d", $realtime, exp_a.yaw,
                   $signed(m_axis_tdata[46:31]));
        end
        if (m_axis_tdata[47] !== 1'b0) begin
          errors++;
          $display("%0t: pad bit expected 0 actual %b", $realtime, m_axis_tdata[47]);
        end
        if (m_axis_tuser !== exp_a.clamped) begin
          errors++;
          $display("%0t: clamp flag expected %b actual %b", $realtime, exp_a.clamped,
                   m_axis_tuser);
        end
      end
    end
  end

  // Watchdog on cycles with no accepted item on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WDOG_LIMIT) begin
      $display("quaternion_to_euler_angles: mismatch");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

endmodule
